[design/ike_pkg.sv]
// Shared types, constants and hash helpers for the identity key derivation block.
// No dependencies; every other design file imports this package.
package ike_pkg;

  localparam int WORD_W = 32;
  localparam int ID_WORDS = 3;

  // Hash lanes: identity key words 0..3, encryption key words 0..3, address fold
  localparam int NUM_LANES = 9;
  localparam int LANE_ADDR = 8;

  // Pipeline depth: two register stages per absorbed ID word, then the output stage
  localparam int MIX_STAGES = 2 * ID_WORDS;
  localparam int NUM_STAGES = MIX_STAGES + 1;

  localparam logic [WORD_W-1:0] UNPROGRAMMED_NUMBER = 32'hffffffff;
  localparam logic [WORD_W-1:0] DOMAIN_IDENTITY = 32'h49524b00;
  localparam logic [WORD_W-1:0] DOMAIN_ENCRYPTION = 32'h45524b00;
  localparam logic [WORD_W-1:0] DOMAIN_ADDRESS = 32'h41445200;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 32'h846ca68b;

  typedef struct packed {
    logic [31:0] unique_id_first;
    logic [31:0] unique_id_second;
    logic [31:0] unique_id_third;
    logic [31:0] assigned_number;
    logic [7:0]  device_id_byte;
    logic [23:0] company_id;
  } req_t;

  typedef struct packed {
    logic [47:0] device_address;
    logic [63:0] identity_key_low;
    logic [63:0] identity_key_high;
    logic [63:0] encryption_key_low;
    logic [63:0] encryption_key_high;
  } rsp_t;

  function automatic logic [WORD_W-1:0] xs16(input logic [WORD_W-1:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [WORD_W-1:0] xs15(input logic [WORD_W-1:0] v);
    return v ^ (v >> 15);
  endfunction

  // Full mixer, used only on constants to pre-mix the lane seeds
  function automatic logic [WORD_W-1:0] hash_mix(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = xs16(v);
    t = WORD_W'(t * MIX_MUL_A);
    t = xs15(t);
    t = WORD_W'(t * MIX_MUL_B);
    return xs16(t);
  endfunction

  // Seed of each lane after its first mix
  localparam logic [WORD_W-1:0] LANE_SEED [NUM_LANES] = '{
    hash_mix(DOMAIN_IDENTITY + 32'd0),
    hash_mix(DOMAIN_IDENTITY + 32'd1),
    hash_mix(DOMAIN_IDENTITY + 32'd2),
    hash_mix(DOMAIN_IDENTITY + 32'd3),
    hash_mix(DOMAIN_ENCRYPTION + 32'd0),
    hash_mix(DOMAIN_ENCRYPTION + 32'd1),
    hash_mix(DOMAIN_ENCRYPTION + 32'd2),
    hash_mix(DOMAIN_ENCRYPTION + 32'd3),
    hash_mix(DOMAIN_ADDRESS)
  };

endpackage

[design/ike_req_if.sv]
// Request channel: factory record with valid/ready handshake.
// Depends on ike_pkg for the payload type.
interface ike_req_if;
  import ike_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ike_rsp_if.sv]
// Response channel: device address and root keys with valid/ready handshake.
// Depends on ike_pkg for the payload type.
interface ike_rsp_if;
  import ike_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ble_identity_key_derivation.sv]
// Pipeline: 6 hash stages then an output register, from request accept to response valid.
// Throughput: one request per cycle unless stalled; each stage holds one multiply of the
// 32-bit mixer, nine hash lanes side by side. Per-stage ready lets bubbles close under stall.
// Reset clears every stage valid bit; payload registers are not reset.
// Depends on ike_pkg, ike_req_if and ike_rsp_if.
module ble_identity_key_derivation (
  input logic clk,
  input logic rst,
  ike_req_if.sink req,
  ike_rsp_if.source rsp
);
  import ike_pkg::*;

  typedef struct packed {
    logic [ID_WORDS-1:0][WORD_W-1:0] id;
    logic        programmed;
    logic [15:0] number_low;
    logic [7:0]  device_id_byte;
    logic [23:0] company_id;
  } side_t;

  logic [NUM_LANES-1:0][WORD_W-1:0] acc [MIX_STAGES];
  logic [NUM_LANES-1:0][WORD_W-1:0] acc_next [MIX_STAGES];
  side_t side [MIX_STAGES];
  side_t side_in;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;
  rsp_t out_data;
  rsp_t out_data_next;

  // Pack the request side data carried down the pipe
  always_comb begin
    side_in.id[0] = req.data.unique_id_first;
    side_in.id[1] = req.data.unique_id_second;
    side_in.id[2] = req.data.unique_id_third;
    side_in.programmed = (req.data.assigned_number != UNPROGRAMMED_NUMBER);
    side_in.number_low = req.data.assigned_number[15:0];
    side_in.device_id_byte = req.data.device_id_byte;
    side_in.company_id = req.data.company_id;
  end

  // Advance a stage when it is empty or the next one takes its contents
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || rsp.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign req.ready = en[0];

  // Mixer halves: even stages absorb an ID word and multiply by A, odd ones by B
  always_comb begin
    logic [WORD_W-1:0] x;
    x = '0;
    for (int s = 0; s < MIX_STAGES; s++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (s % 2 == 0) begin
          if (s == 0) begin
            x = LANE_SEED[l] ^ req.data.unique_id_first;
          end else begin
            x = xs16(acc[s-1][l]) ^ side[s-1].id[s/2];
          end
          x = xs16(x);
          acc_next[s][l] = WORD_W'(x * MIX_MUL_A);
        end else begin
          x = xs15(acc[s-1][l]);
          acc_next[s][l] = WORD_W'(x * MIX_MUL_B);
        end
      end
    end
  end

  // Finish the last mix, pick the address source, pack the keys
  always_comb begin
    logic [NUM_LANES-1:0][WORD_W-1:0] w;
    side_t sd;
    for (int l = 0; l < NUM_LANES; l++) begin
      w[l] = xs16(acc[MIX_STAGES-1][l]);
    end
    sd = side[MIX_STAGES-1];
    out_data_next.device_address = {sd.company_id, sd.device_id_byte,
                                    sd.programmed ? sd.number_low : w[LANE_ADDR][15:0]};
    out_data_next.identity_key_low = {w[1], w[0]};
    out_data_next.identity_key_high = {w[3], w[2]};
    out_data_next.encryption_key_low = {w[5], w[4]};
    out_data_next.encryption_key_high = {w[7], w[6]};
  end

  // Hold or advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          vld[s] <= (s == 0) ? req.valid : vld[s-1];
        end
      end
    end
  end

  // Hold or advance payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < MIX_STAGES; s++) begin
      if (en[s]) begin
        acc[s] <= acc_next[s];
        side[s] <= (s == 0) ? side_in : side[s-1];
      end
    end
    if (en[NUM_STAGES-1]) begin
      out_data <= out_data_next;
    end
  end

  assign rsp.valid = vld[NUM_STAGES-1];
  assign rsp.data = out_data;

endmodule

[design/ike_checker.sv]
// Port-level checks for the identity key derivation block, bound to its top level.
// Depends on ike_pkg for the response type and pipeline depth.
module ike_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input ike_pkg::rsp_t rsp_data
);
  import ike_pkg::*;

  logic [3:0] pending;

  // Track requests in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= 4'(pending + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready));
    end
  end

  // A stalled response keeps its data
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  // No response without a request in flight
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 4'd0)
    else $error("response with no request in flight");

  // In-flight count never exceeds the pipeline depth
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(NUM_STAGES))
    else $error("more requests in flight than stages");

  // An open output never back-pressures the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    rsp_ready |-> req_ready)
    else $error("input stalled while output is ready");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind ble_identity_key_derivation ike_checker u_ike_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);
